/* rtl/core/pmss_pkg.sv */
// shared types, constants and register codes of the pointer motion and scroll shaper
`default_nettype none

package pmss_pkg;

  // field and register widths
  localparam int unsigned FIELD_W   = 8;
  localparam int unsigned GAIN_W    = 14;
  localparam int unsigned BUF_W     = 8;
  localparam int unsigned LOCK_W    = 2;
  localparam int unsigned ACC_W     = 10;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned PROD_W    = FIELD_W + GAIN_W;

  // gain and clamp constants
  localparam int unsigned XY_LIMIT  = 127;
  localparam int unsigned HV_LIMIT  = 127;
  localparam int unsigned DRAG_GAIN = 10;
  localparam int unsigned GAIN_UNIT = 100;

  // a product at or above this saturates the quotient
  localparam int unsigned SAT_PRODUCT = (XY_LIMIT + 1) * GAIN_UNIT;
  // floor(m / 100) == (m * 5243) >> 19 for every m below SAT_PRODUCT
  localparam int unsigned DIV_RECIP   = 5243;
  localparam int unsigned DIV_SHIFT   = 19;
  localparam int unsigned DIV_IN_W    = 14;
  localparam int unsigned DIV_RECIP_W = 13;
  localparam int unsigned QUOT_W      = 7;

  // register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEFAULT_MULT = 3'd0,
    REG_SNIPING_MULT = 3'd1,
    REG_SNIPING_ON   = 3'd2,
    REG_DRAG_ON      = 3'd3,
    REG_INVERTED     = 3'd4,
    REG_BUF_SIZE     = 3'd5,
    REG_LOCK_MODE    = 3'd6
  } reg_idx_t;

  // scroll lock codes
  localparam logic [LOCK_W-1:0] LOCK_BOTH  = 2'd0;
  localparam logic [LOCK_W-1:0] LOCK_HORIZ = 2'd1;
  localparam logic [LOCK_W-1:0] LOCK_VERT  = 2'd2;
  // unused code, masks both scroll axes
  localparam logic [LOCK_W-1:0] LOCK_NONE  = 2'd3;

  // register reset values
  localparam logic [GAIN_W-1:0] DEFAULT_MULT_RST = 14'd350;
  localparam logic [GAIN_W-1:0] SNIPING_MULT_RST = 14'd100;
  localparam logic [BUF_W-1:0]  BUF_SIZE_RST     = 8'd5;

  // configuration state seen by the datapath
  typedef struct packed {
    logic [GAIN_W-1:0] default_mult;
    logic [GAIN_W-1:0] sniping_mult;
    logic              sniping_on;
    logic              drag_on;
    logic              inverted;
    logic [BUF_W-1:0]  buf_size;
    logic [LOCK_W-1:0] lock_mode;
  } cfg_t;

  // payload after the gain multiply
  typedef struct packed {
    logic [PROD_W-1:0]  mag_x;
    logic [PROD_W-1:0]  mag_y;
    logic               neg_x;
    logic               neg_y;
    logic [FIELD_W-1:0] wheel_h;
    logic [FIELD_W-1:0] wheel_v;
  } prod_t;

endpackage

`default_nettype wire

/* rtl/core/pointer_motion_scroll_shaper.sv */
// top level of the pointer motion and scroll shaper: ports, registers, pipeline control
//
//   channel   direction  beat contents (low bits first)
//   in_*      slave      move_x, move_y, wheel_h, wheel_v   (8 bit signed each)
//   out_*     master     out_x, out_y, out_h, out_v         (8 bit signed each)
//   cfg_*     write      register index and data, no read-back
//
// three register stages: input, gain product, result; a beat passes through them in that order
// one beat per cycle sustained while out_tready is high; each stage moves when the one after it is empty or moving
// the input register keeps accepting while a result waits, until all stages are full
// rst_n clears valids, scroll accumulators and configuration; payload is not reset
`default_nettype none

module pointer_motion_scroll_shaper
  import pmss_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // input stream
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [4*FIELD_W-1:0]   in_tdata,   // move_x, move_y, wheel_h, wheel_v
  // result stream
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [4*FIELD_W-1:0]        out_tdata,  // out_x, out_y, out_h, out_v
  // configuration writes
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [GAIN_W-1:0]      cfg_wdata
);

  cfg_t               cfg_r;
  logic               in_vld_r;
  logic               prod_vld_r;
  logic               out_vld_r;
  logic               rdy_in;
  logic               rdy_prod;
  logic               rdy_out;
  logic [FIELD_W-1:0] move_x_r;
  logic [FIELD_W-1:0] move_y_r;
  logic [FIELD_W-1:0] wheel_h_r;
  logic [FIELD_W-1:0] wheel_v_r;
  prod_t              prod_r;
  logic [FIELD_W-1:0] out_x_r;
  logic [FIELD_W-1:0] out_y_r;
  logic [FIELD_W-1:0] out_h_r;
  logic [FIELD_W-1:0] out_v_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.default_mult <= DEFAULT_MULT_RST;
      cfg_r.sniping_mult <= SNIPING_MULT_RST;
      cfg_r.sniping_on   <= 1'b0;
      cfg_r.drag_on      <= 1'b0;
      cfg_r.inverted     <= 1'b0;
      cfg_r.buf_size     <= BUF_SIZE_RST;
      cfg_r.lock_mode    <= LOCK_BOTH;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_DEFAULT_MULT: cfg_r.default_mult <= cfg_wdata;
        REG_SNIPING_MULT: cfg_r.sniping_mult <= cfg_wdata;
        REG_SNIPING_ON:   cfg_r.sniping_on   <= cfg_wdata[0];
        REG_DRAG_ON:      cfg_r.drag_on      <= cfg_wdata[0];
        REG_INVERTED:     cfg_r.inverted     <= cfg_wdata[0];
        REG_BUF_SIZE:     cfg_r.buf_size     <= cfg_wdata[BUF_W-1:0];
        REG_LOCK_MODE:    cfg_r.lock_mode    <= cfg_wdata[LOCK_W-1:0];
        default: ;
      endcase
    end
  end

  // per-stage ready: a stage may load when it is empty or the stage after it is loading
  assign rdy_out  = !out_vld_r || out_tready;
  assign rdy_prod = !prod_vld_r || rdy_out;
  assign rdy_in   = !in_vld_r || rdy_prod;

  assign in_tready  = rdy_in;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_v_r, out_h_r, out_y_r, out_x_r};

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      prod_vld_r <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      if (rdy_in) begin
        in_vld_r <= in_tvalid;
      end
      if (rdy_prod) begin
        prod_vld_r <= in_vld_r;
      end
      if (rdy_out) begin
        out_vld_r <= prod_vld_r;
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rdy_in) begin
      move_x_r  <= in_tdata[0*FIELD_W +: FIELD_W];
      move_y_r  <= in_tdata[1*FIELD_W +: FIELD_W];
      wheel_h_r <= in_tdata[2*FIELD_W +: FIELD_W];
      wheel_v_r <= in_tdata[3*FIELD_W +: FIELD_W];
    end
  end

  // gain multiply stage
  pmss_scale u_scale (
    .clk     (clk),
    .load    (rdy_prod),
    .cfg     (cfg_r),
    .move_x  (move_x_r),
    .move_y  (move_y_r),
    .wheel_h (wheel_h_r),
    .wheel_v (wheel_v_r),
    .prod_r  (prod_r)
  );

  // scroll shaping and result stage
  pmss_scroll u_scroll (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (rdy_out),
    .update  (rdy_out && prod_vld_r),
    .cfg     (cfg_r),
    .prod    (prod_r),
    .out_x_r (out_x_r),
    .out_y_r (out_y_r),
    .out_h_r (out_h_r),
    .out_v_r (out_v_r)
  );

endmodule

`default_nettype wire

/* rtl/core/pmss_scale.sv */
// gain selection and magnitude multiply stage for the two motion axes
`default_nettype none

module pmss_scale
  import pmss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               load,
  input  wire cfg_t               cfg,
  input  wire logic [FIELD_W-1:0] move_x,
  input  wire logic [FIELD_W-1:0] move_y,
  input  wire logic [FIELD_W-1:0] wheel_h,
  input  wire logic [FIELD_W-1:0] wheel_v,
  output prod_t                   prod_r
);

  logic [GAIN_W-1:0]  gain;
  logic [FIELD_W-1:0] abs_x;
  logic [FIELD_W-1:0] abs_y;
  prod_t              prod_nxt;

  // drag scroll overrides the sniping choice
  always_comb begin
    priority if (cfg.drag_on) begin
      gain = GAIN_W'(DRAG_GAIN);
    end else if (cfg.sniping_on) begin
      gain = cfg.sniping_mult;
    end else begin
      gain = cfg.default_mult;
    end
  end

  // magnitudes of the raw deltas, -128 maps to 128
  assign abs_x = move_x[FIELD_W-1] ? (~move_x + FIELD_W'(1)) : move_x;
  assign abs_y = move_y[FIELD_W-1] ? (~move_y + FIELD_W'(1)) : move_y;

  // unsigned products, sign carried alongside
  always_comb begin
    prod_nxt.mag_x   = PROD_W'(abs_x) * PROD_W'(gain);
    prod_nxt.mag_y   = PROD_W'(abs_y) * PROD_W'(gain);
    prod_nxt.neg_x   = move_x[FIELD_W-1];
    prod_nxt.neg_y   = move_y[FIELD_W-1];
    prod_nxt.wheel_h = wheel_h;
    prod_nxt.wheel_v = wheel_v;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= prod_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/pmss_scroll.sv */
// divide, clamp, drag routing, scroll buffering, lock mask and result register
`default_nettype none

module pmss_scroll
  import pmss_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire logic               update,
  input  wire cfg_t               cfg,
  input  wire prod_t              prod,
  output logic [FIELD_W-1:0]      out_x_r,
  output logic [FIELD_W-1:0]      out_y_r,
  output logic [FIELD_W-1:0]      out_h_r,
  output logic [FIELD_W-1:0]      out_v_r
);

  // truncated quotient by 100 with saturation at the limit
  function automatic logic [QUOT_W-1:0] div_sat(input logic [PROD_W-1:0] m);
    logic [DIV_IN_W+DIV_RECIP_W-1:0] scaled;
    scaled = (DIV_IN_W+DIV_RECIP_W)'(m[DIV_IN_W-1:0]) *
             (DIV_IN_W+DIV_RECIP_W)'(DIV_RECIP);
    if (m >= PROD_W'(SAT_PRODUCT)) begin
      div_sat = QUOT_W'(XY_LIMIT);
    end else begin
      div_sat = scaled[DIV_SHIFT +: QUOT_W];
    end
  endfunction

  // symmetric clamp of a 9 bit value to the scroll limit
  function automatic logic [FIELD_W-1:0] clamp_hv(input logic signed [FIELD_W:0] val);
    if (val > $signed((FIELD_W+1)'(HV_LIMIT))) begin
      clamp_hv = FIELD_W'(HV_LIMIT);
    end else if (val < -$signed((FIELD_W+1)'(HV_LIMIT))) begin
      clamp_hv = FIELD_W'(-$signed((FIELD_W+1)'(HV_LIMIT)));
    end else begin
      clamp_hv = val[FIELD_W-1:0];
    end
  endfunction

  logic signed [FIELD_W:0]   sx;
  logic signed [FIELD_W:0]   sy;
  logic signed [FIELD_W:0]   h_pre;
  logic signed [FIELD_W:0]   v_pre;
  logic signed [FIELD_W:0]   h_inv;
  logic signed [FIELD_W:0]   v_inv;
  logic [FIELD_W-1:0]        h_clamp;
  logic [FIELD_W-1:0]        v_clamp;
  logic signed [ACC_W-1:0]   acc_h_r;
  logic signed [ACC_W-1:0]   acc_v_r;
  logic signed [ACC_W-1:0]   acc_h_nxt;
  logic signed [ACC_W-1:0]   acc_v_nxt;
  logic signed [ACC_W-1:0]   sum_h;
  logic signed [ACC_W-1:0]   sum_v;
  logic [ACC_W-1:0]          abs_h;
  logic [ACC_W-1:0]          abs_v;
  logic                      over_h;
  logic                      over_v;
  logic                      buf_on;
  logic [FIELD_W-1:0]        h_buf;
  logic [FIELD_W-1:0]        v_buf;
  logic [FIELD_W-1:0]        out_x_nxt;
  logic [FIELD_W-1:0]        out_y_nxt;
  logic [FIELD_W-1:0]        out_h_nxt;
  logic [FIELD_W-1:0]        out_v_nxt;

  // signed scaled motion
  always_comb begin
    sx = $signed({2'b00, div_sat(prod.mag_x)});
    sy = $signed({2'b00, div_sat(prod.mag_y)});
    if (prod.neg_x) begin
      sx = -sx;
    end
    if (prod.neg_y) begin
      sy = -sy;
    end
  end

  // drag scroll routing, inversion and scroll clamp
  always_comb begin
    if (cfg.drag_on) begin
      h_pre     = sx;
      v_pre     = sy;
      out_x_nxt = '0;
      out_y_nxt = '0;
    end else begin
      h_pre     = $signed({prod.wheel_h[FIELD_W-1], prod.wheel_h});
      v_pre     = $signed({prod.wheel_v[FIELD_W-1], prod.wheel_v});
      out_x_nxt = sx[FIELD_W-1:0];
      out_y_nxt = sy[FIELD_W-1:0];
    end
    h_inv   = cfg.inverted ? -h_pre : h_pre;
    v_inv   = cfg.inverted ? -v_pre : v_pre;
    h_clamp = clamp_hv(h_inv);
    v_clamp = clamp_hv(v_inv);
  end

  // per-axis accumulation into single steps; a zero buf_size passes the clamped value through
  assign buf_on = (cfg.buf_size != '0);
  assign sum_h  = acc_h_r + $signed({{(ACC_W-FIELD_W){h_clamp[FIELD_W-1]}}, h_clamp});
  assign sum_v  = acc_v_r + $signed({{(ACC_W-FIELD_W){v_clamp[FIELD_W-1]}}, v_clamp});
  assign abs_h  = sum_h[ACC_W-1] ? ACC_W'(-sum_h) : ACC_W'(sum_h);
  assign abs_v  = sum_v[ACC_W-1] ? ACC_W'(-sum_v) : ACC_W'(sum_v);
  assign over_h = abs_h > ACC_W'(cfg.buf_size);
  assign over_v = abs_v > ACC_W'(cfg.buf_size);

  always_comb begin
    h_buf     = '0;
    v_buf     = '0;
    acc_h_nxt = acc_h_r;
    acc_v_nxt = acc_v_r;
    if (buf_on) begin
      acc_h_nxt = over_h ? '0 : sum_h;
      acc_v_nxt = over_v ? '0 : sum_v;
      if (over_h) begin
        h_buf = sum_h[ACC_W-1] ? '1 : FIELD_W'(1);
      end
      if (over_v) begin
        v_buf = sum_v[ACC_W-1] ? '1 : FIELD_W'(1);
      end
    end else begin
      h_buf = h_clamp;
      v_buf = v_clamp;
    end
  end

  // scroll lock masks the output only
  always_comb begin
    out_h_nxt = ((cfg.lock_mode == LOCK_BOTH) || (cfg.lock_mode == LOCK_HORIZ)) ? h_buf : '0;
    out_v_nxt = ((cfg.lock_mode == LOCK_BOTH) || (cfg.lock_mode == LOCK_VERT))  ? v_buf : '0;
  end

  // accumulators advance once per beat loaded into the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_h_r <= '0;
      acc_v_r <= '0;
    end else if (update) begin
      acc_h_r <= acc_h_nxt;
      acc_v_r <= acc_v_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (load) begin
      out_x_r <= out_x_nxt;
      out_y_r <= out_y_nxt;
      out_h_r <= out_h_nxt;
      out_v_r <= out_v_nxt;
    end
  end

endmodule

`default_nettype wire
